FILE: sv/scfla_pkg.sv
// ----------------------------------------------------------------------------
// scfla_pkg - shared definitions for the size-class free-list allocator
// Pool geometry, size classes, status codes and the memory access bundle.
// ----------------------------------------------------------------------------
package scfla_pkg;

  localparam int POOL_PAGES      = 64;
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = 12;
  localparam int UNIT_SHIFT      = 4;
  localparam int HEADER_BYTES    = 8;
  localparam int MIN_BLOCK       = 16;
  localparam int MAX_CLASS_BYTES = 2048;
  localparam int NUM_CLASSES     = 8;

  localparam int ADDR_W   = 18;
  localparam int REQ_W    = 20;
  localparam int TOTAL_W  = 21;
  localparam int UNIT_W   = 14;
  localparam int HEAD_W   = 15;
  localparam int PAGE_W   = 6;
  localparam int USED_W   = 7;
  localparam int CLS_W    = 3;
  localparam int SIZE_W   = 12;
  localparam int LEFT_W   = 9;
  localparam int PCNT_W   = 9;
  localparam int LIMIT_W  = 7;

  localparam int LINK_DEPTH = (POOL_PAGES * PAGE_BYTES) >> UNIT_SHIFT;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_LARGE = 2'd1,
    STS_OOM   = 2'd2,
    STS_BADDR = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  // Access bundle from the control logic to the store
  typedef struct packed {
    logic              link_re;
    logic [UNIT_W-1:0] link_raddr;
    logic              link_we;
    logic [UNIT_W-1:0] link_waddr;
    logic [HEAD_W-1:0] link_wdata;
    logic              tag_re;
    logic [PAGE_W-1:0] tag_raddr;
    logic              tag_we;
    logic [PAGE_W-1:0] tag_waddr;
    logic [CLS_W-1:0]  tag_wdata;
  } mem_req_t;

  // Smallest class whose block size covers total (total within 16..2048)
  function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_W-1:0] total);
    logic [CLS_W-1:0] k;
    k = CLS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (total <= SIZE_W'(MIN_BLOCK << i)) k = CLS_W'(i);
    end
    return k;
  endfunction

  function automatic logic [SIZE_W-1:0] class_size(input logic [CLS_W-1:0] k);
    return SIZE_W'(MIN_BLOCK) << k;
  endfunction

endpackage

FILE: sv/scfla_ifs.sv
// ----------------------------------------------------------------------------
// scfla channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scfla_req_if import scfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [REQ_W-1:0]  req_bytes;
  logic [ADDR_W-1:0] user_addr;

  modport source (output valid, mode, req_bytes, user_addr, input ready);
  modport sink   (input valid, mode, req_bytes, user_addr, output ready);
endinterface

interface scfla_rsp_if import scfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] result_addr;
  logic [SIZE_W-1:0] class_bytes;
  logic [PCNT_W-1:0] page_count;

  modport source (output valid, status, result_addr, class_bytes, page_count,
                  input ready);
  modport sink   (input valid, status, result_addr, class_bytes, page_count,
                  output ready);
endinterface

interface scfla_cfg_if import scfla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] pool_page_limit;

  modport source (output valid, pool_page_limit, input ready);
  modport sink   (input valid, pool_page_limit, output ready);
endinterface

FILE: sv/size_class_free_list_allocator.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator - segregated free-list block allocator
// Eight power-of-two block classes carved from a pool of 4 KiB pages.
// ----------------------------------------------------------------------------
// Each request passes two steps: the accept step works out the class and
// starts the reads of the link memory (next free block of the class) and the
// page tag memory (class of the page being freed); the S_EXEC step updates
// the list head, carve cursor or page count, writes the memories back and
// loads the result register. A new request is taken once the previous one has
// reached the result register, so a sink that holds off also holds off the
// next request. Both memories are undefined after reset and need no
// clearing pass; requests and configuration writes are held off while reset
// is asserted and are taken once it is released.
module size_class_free_list_allocator import scfla_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  scfla_req_if.sink  in_chan,
  scfla_rsp_if.source out_chan,
  scfla_cfg_if.sink  cfg_chan
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;

  logic [HEAD_W-1:0]  bin_head_r     [NUM_CLASSES];
  logic [UNIT_W-1:0]  carve_cursor_r [NUM_CLASSES];
  logic [LEFT_W-1:0]  carve_left_r   [NUM_CLASSES];
  logic [USED_W-1:0]  pages_used_r;
  logic [LIMIT_W-1:0] limit_r;

  // request held for the S_EXEC step
  logic               mode_r;
  logic               large_r;
  logic [CLS_W-1:0]   k_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic [ADDR_W-1:0]  blk_r;
  logic               low_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [SIZE_W-1:0]  out_cls_r;
  logic [PCNT_W-1:0]  out_pcnt_r;

  mem_req_t           mreq;
  logic [HEAD_W-1:0]  link_rdata;
  logic [CLS_W-1:0]   tag_rdata;

  scfla_store u_store (
    .clk        (clk),
    .mreq       (mreq),
    .link_rdata (link_rdata),
    .tag_rdata  (tag_rdata)
  );

  // ---- accept cycle: class selection and memory read issue ----
  logic               accept;
  logic [TOTAL_W-1:0] total_raw;
  logic [TOTAL_W-1:0] total_c;
  logic [TOTAL_W-1:0] pc_sum;
  logic               large_c;
  logic [CLS_W-1:0]   k_c;
  logic [ADDR_W-1:0]  blk_c;

  assign in_chan.ready = rst_n && (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = rst_n;

  always_comb begin
    total_raw = TOTAL_W'(in_chan.req_bytes) + TOTAL_W'(HEADER_BYTES);
    total_c   = (total_raw < TOTAL_W'(MIN_BLOCK)) ? TOTAL_W'(MIN_BLOCK) : total_raw;
    large_c   = total_c > TOTAL_W'(MAX_CLASS_BYTES);
    pc_sum    = total_c + TOTAL_W'(PAGE_BYTES - 1);
    k_c       = class_of(total_c[SIZE_W-1:0]);
    blk_c     = in_chan.user_addr - ADDR_W'(HEADER_BYTES);
  end

  // ---- S_EXEC step: read-modify-write ----
  logic               fire;
  logic [LIMIT_W-1:0] limit_eff;
  logic [SIZE_W-1:0]  a_size;
  logic               a_pop;
  logic               a_carve;
  logic               a_fresh;
  logic               a_oom;
  logic [ADDR_W-1:0]  a_blk;
  logic [CLS_W-1:0]   f_cls;
  logic [SIZE_W-1:0]  f_size;
  logic               f_bad;
  logic [PAGE_W-1:0]  f_page;
  logic [1:0]         st_c;
  logic [ADDR_W-1:0]  addr_c;
  logic [SIZE_W-1:0]  cls_c;
  logic [PCNT_W-1:0]  pcnt_c;

  assign fire = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);

  always_comb begin
    limit_eff = (limit_r > LIMIT_W'(POOL_PAGES)) ? LIMIT_W'(POOL_PAGES) : limit_r;
    a_size    = class_size(k_r);
    a_pop     = bin_head_r[k_r][HEAD_W-1];
    a_carve   = !a_pop && (carve_left_r[k_r] != '0);
    a_oom     = !a_pop && !a_carve && (pages_used_r >= limit_eff);
    a_fresh   = !a_pop && !a_carve && !a_oom;
    if (a_pop) begin
      a_blk = ADDR_W'(bin_head_r[k_r][UNIT_W-1:0]) << UNIT_SHIFT;
    end else if (a_carve) begin
      a_blk = ADDR_W'(carve_cursor_r[k_r]) << UNIT_SHIFT;
    end else begin
      a_blk = ADDR_W'(pages_used_r[PAGE_W-1:0]) << PAGE_SHIFT;
    end

    f_page = blk_r[ADDR_W-1:PAGE_SHIFT];
    f_cls  = tag_rdata;
    f_size = class_size(f_cls);
    f_bad  = low_r || (USED_W'(f_page) >= pages_used_r) ||
             ((blk_r[PAGE_SHIFT-1:0] & (f_size - SIZE_W'(1))) != '0);

    st_c   = STS_OK;
    addr_c = '0;
    cls_c  = '0;
    pcnt_c = '0;
    if (mode_r == MODE_FREE) begin
      if (f_bad) begin
        st_c = STS_BADDR;
      end else begin
        cls_c = f_size;
      end
    end else if (large_r) begin
      st_c   = STS_LARGE;
      pcnt_c = pcnt_r;
    end else if (a_oom) begin
      st_c = STS_OOM;
    end else begin
      addr_c = a_blk + ADDR_W'(HEADER_BYTES);
      cls_c  = a_size;
    end
  end

  always_comb begin
    mreq            = '0;
    mreq.link_re    = accept && (in_chan.mode == MODE_ALLOC);
    mreq.link_raddr = bin_head_r[k_c][UNIT_W-1:0];
    mreq.tag_re     = accept && (in_chan.mode == MODE_FREE);
    mreq.tag_raddr  = blk_c[ADDR_W-1:PAGE_SHIFT];
    if (fire && (mode_r == MODE_FREE) && !f_bad) begin
      mreq.link_we    = 1'b1;
      mreq.link_waddr = blk_r[ADDR_W-1:UNIT_SHIFT];
      mreq.link_wdata = bin_head_r[f_cls];
    end
    if (fire && (mode_r == MODE_ALLOC) && !large_r && a_fresh) begin
      mreq.tag_we    = 1'b1;
      mreq.tag_waddr = pages_used_r[PAGE_W-1:0];
      mreq.tag_wdata = k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pages_used_r <= '0;
      limit_r      <= LIMIT_W'(POOL_PAGES);
      for (int i = 0; i < NUM_CLASSES; i++) begin
        bin_head_r[i]     <= '0;
        carve_cursor_r[i] <= '0;
        carve_left_r[i]   <= '0;
      end
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        limit_r <= cfg_chan.pool_page_limit;
      end
      // drop the result once taken, unless a new one loads in its place
      if (out_valid_r && out_chan.ready && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= st_c;
            out_addr_r   <= addr_c;
            out_cls_r    <= cls_c;
            out_pcnt_r   <= pcnt_c;
            if (mode_r == MODE_FREE) begin
              // push onto the tagged class's list
              if (!f_bad) begin
                bin_head_r[f_cls] <= {1'b1, blk_r[ADDR_W-1:UNIT_SHIFT]};
              end
            end else if (!large_r) begin
              if (a_pop) begin
                bin_head_r[k_r] <= link_rdata;
              end else if (a_carve) begin
                carve_cursor_r[k_r] <= carve_cursor_r[k_r] + UNIT_W'(a_size >> UNIT_SHIFT);
                carve_left_r[k_r]   <= carve_left_r[k_r] - LEFT_W'(1);
              end else if (a_fresh) begin
                carve_cursor_r[k_r] <= {pages_used_r[PAGE_W-1:0], (PAGE_SHIFT-UNIT_SHIFT)'(0)}
                                       + UNIT_W'(a_size >> UNIT_SHIFT);
                carve_left_r[k_r]   <= (LEFT_W'(PAGE_BYTES >> UNIT_SHIFT) >> k_r) - LEFT_W'(1);
                pages_used_r        <= pages_used_r + USED_W'(1);
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // latch the request for the S_EXEC step
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_chan.mode;
      large_r <= large_c;
      k_r     <= k_c;
      pcnt_r  <= pc_sum[TOTAL_W-1:PAGE_SHIFT];
      blk_r   <= blk_c;
      low_r   <= in_chan.user_addr < ADDR_W'(HEADER_BYTES);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.result_addr = out_addr_r;
  assign out_chan.class_bytes = out_cls_r;
  assign out_chan.page_count  = out_pcnt_r;

endmodule

FILE: sv/scfla_store.sv
// ----------------------------------------------------------------------------
// scfla_store - free-list link memory and page class tag memory
// Single write and single registered read port on each memory.
// ----------------------------------------------------------------------------
module scfla_store import scfla_pkg::*; (
  input  logic              clk,
  input  mem_req_t          mreq,
  output logic [HEAD_W-1:0] link_rdata,
  output logic [CLS_W-1:0]  tag_rdata
);

  logic [HEAD_W-1:0] link_mem [LINK_DEPTH];
  logic [CLS_W-1:0]  tag_mem  [POOL_PAGES];

  always_ff @(posedge clk) begin
    if (mreq.link_we) begin
      link_mem[mreq.link_waddr] <= mreq.link_wdata;
    end
    if (mreq.link_re) begin
      link_rdata <= link_mem[mreq.link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.tag_we) begin
      tag_mem[mreq.tag_waddr] <= mreq.tag_wdata;
    end
    if (mreq.tag_re) begin
      tag_rdata <= tag_mem[mreq.tag_raddr];
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the size-class free-list allocator
// Drives allocate and free requests over the request channel and keeps a
// shadow of the pool: free lists, carve cursors, page tags and page count.
// Each result is checked field by field against the shadow's outcome, under
// random stalls on both sides, pool page limits from 0 to 127 and a
// full-rate tail.
// ----------------------------------------------------------------------------
module tb_top;
  import scfla_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int LONG_HOLD  = 200;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] result_addr;
    logic [SIZE_W-1:0] class_bytes;
    logic [PCNT_W-1:0] page_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  scfla_req_if in_if ();
  scfla_rsp_if out_if ();
  scfla_cfg_if cfg_if ();

  size_class_free_list_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow pool
  logic [HEAD_W-1:0]  free_top [NUM_CLASSES];
  logic [HEAD_W-1:0]  next_free [LINK_DEPTH];
  int unsigned        carve_at [NUM_CLASSES];
  int unsigned        carve_count [NUM_CLASSES];
  logic [CLS_W-1:0]   page_class [POOL_PAGES];
  int unsigned        pages_taken;
  logic [LIMIT_W-1:0] page_limit;

  outcome_t          pending_outcomes[$];
  logic [ADDR_W-1:0] live_blocks[$];

  int unsigned mismatches;
  int unsigned status_count [4];
  bit          sender_idling;
  bit          sink_idling;
  bit          hold_off_request;

  function automatic outcome_t allocate_or_free(input mode_t op,
                                                input logic [REQ_W-1:0] req,
                                                input logic [ADDR_W-1:0] uaddr);
    outcome_t    o;
    int unsigned total, blk, pg, k, sz, lim;
    logic [UNIT_W-1:0] unit;
    o = '{STS_OK, '0, '0, '0};
    if (op == MODE_ALLOC) begin
      total = req + HEADER_BYTES;
      if (total < MIN_BLOCK) total = MIN_BLOCK;
      if (total > MAX_CLASS_BYTES) begin
        o.status     = STS_LARGE;
        o.page_count = PCNT_W'((total + PAGE_BYTES - 1) / PAGE_BYTES);
        return o;
      end
      k = 0;
      while ((MIN_BLOCK << k) < total) k++;
      sz = MIN_BLOCK << k;
      if (free_top[k][HEAD_W-1]) begin
        // pop the most recently freed block
        unit        = free_top[k][UNIT_W-1:0];
        blk         = unit << UNIT_SHIFT;
        free_top[k] = next_free[unit];
      end else if (carve_count[k] != 0) begin
        blk = carve_at[k] << UNIT_SHIFT;
        carve_at[k]    += sz >> UNIT_SHIFT;
        carve_count[k] -= 1;
      end else begin
        lim = (page_limit < POOL_PAGES) ? page_limit : POOL_PAGES;
        if (pages_taken >= lim) begin
          o.status = STS_OOM;
          return o;
        end
        page_class[pages_taken] = CLS_W'(k);
        blk            = pages_taken * PAGE_BYTES;
        carve_at[k]    = (blk + sz) >> UNIT_SHIFT;
        carve_count[k] = PAGE_BYTES / sz - 1;
        pages_taken++;
      end
      o.result_addr = ADDR_W'(blk + HEADER_BYTES);
      o.class_bytes = SIZE_W'(sz);
    end else begin
      if (uaddr < HEADER_BYTES) begin
        o.status = STS_BADDR;
        return o;
      end
      blk = uaddr - HEADER_BYTES;
      pg  = blk / PAGE_BYTES;
      if (pg >= pages_taken) begin
        o.status = STS_BADDR;
        return o;
      end
      sz = MIN_BLOCK << page_class[pg];
      if (((blk % PAGE_BYTES) % sz) != 0) begin
        o.status = STS_BADDR;
        return o;
      end
      unit            = UNIT_W'(blk >> UNIT_SHIFT);
      next_free[unit] = free_top[page_class[pg]];
      free_top[page_class[pg]] = {1'b1, unit};
      o.class_bytes   = SIZE_W'(sz);
    end
    return o;
  endfunction

  task automatic send_request(input mode_t op, input logic [REQ_W-1:0] req,
                              input logic [ADDR_W-1:0] uaddr);
    outcome_t o;
    @(negedge clk);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= op;
    in_if.req_bytes <= req;
    in_if.user_addr <= uaddr;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    o = allocate_or_free(op, req, uaddr);
    pending_outcomes.push_back(o);
    if (op == MODE_ALLOC && o.status == STS_OK) live_blocks.push_back(o.result_addr);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only call with the block idle
  task automatic write_pool_limit(input logic [LIMIT_W-1:0] lim);
    @(negedge clk);
    cfg_if.valid           <= 1'b1;
    cfg_if.pool_page_limit <= lim;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    page_limit = lim;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random(input int unsigned alloc_pct, input int unsigned free_pct,
                             input bit heavy);
    int unsigned r, k, lo, hi, idx;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] uaddr;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      if ($urandom_range(0, 19) == 0) begin
        req = $urandom_range(0, 1) ? REQ_W'($urandom_range(2041, 8192))
                                   : REQ_W'($urandom_range(8193, 1048575));
      end else begin
        k  = heavy ? $urandom_range(4, 7) : $urandom_range(0, 7);
        hi = (MIN_BLOCK << k) - HEADER_BYTES;
        lo = (k == 0) ? 0 : (MIN_BLOCK << (k - 1)) - HEADER_BYTES + 1;
        case ($urandom_range(0, 3))
          0:       req = REQ_W'(lo);
          1:       req = REQ_W'(hi);
          default: req = REQ_W'($urandom_range(lo, hi));
        endcase
      end
      send_request(MODE_ALLOC, req, ADDR_W'($urandom));
    end else if (r < alloc_pct + free_pct && live_blocks.size() != 0) begin
      idx   = $urandom_range(0, live_blocks.size() - 1);
      uaddr = live_blocks[idx];
      // keep the block listed now and then, so it gets freed twice
      if ($urandom_range(0, 19) != 0) live_blocks.delete(idx);
      send_request(MODE_FREE, REQ_W'($urandom), uaddr);
    end else begin
      case ($urandom_range(0, 3))
        0: uaddr = ADDR_W'($urandom);
        1: uaddr = ADDR_W'($urandom_range(0, HEADER_BYTES - 1));
        2: uaddr = (live_blocks.size() != 0)
                   ? live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                     + ADDR_W'($urandom_range(1, 15))
                   : ADDR_W'($urandom);
        default: uaddr = ADDR_W'($urandom_range(0, pages_taken * PAGE_BYTES));
      endcase
      send_request(MODE_FREE, REQ_W'($urandom), uaddr);
    end
  endtask

  task automatic test_limit_extremes();
    write_pool_limit(LIMIT_W'(0));
    send_request(MODE_ALLOC, '0, '0);
    send_request(MODE_FREE, '0, ADDR_W'(HEADER_BYTES));
    send_request(MODE_FREE, '1, '0);
    wait_until_drained();
    write_pool_limit(LIMIT_W'(1));
    send_request(MODE_ALLOC, '0, '1);
    send_request(MODE_ALLOC, REQ_W'(MAX_CLASS_BYTES - HEADER_BYTES), '0);
    send_request(MODE_ALLOC, REQ_W'(HEADER_BYTES), '0);
  endtask

  task automatic test_request_extremes();
    wait_until_drained();
    write_pool_limit('1);
    send_request(MODE_ALLOC, '1, '1);
    send_request(MODE_ALLOC, REQ_W'(MAX_CLASS_BYTES - HEADER_BYTES + 1), '0);
    send_request(MODE_ALLOC, REQ_W'(MAX_CLASS_BYTES - HEADER_BYTES), '0);
    send_request(MODE_ALLOC, REQ_W'(9), '0);
    for (int k = 1; k < NUM_CLASSES - 1; k++)
      send_request(MODE_ALLOC, REQ_W'((MIN_BLOCK << k) - HEADER_BYTES), ADDR_W'($urandom));
  endtask

  task automatic test_free_cases();
    send_request(MODE_FREE, '0, ADDR_W'(HEADER_BYTES + 1));
    send_request(MODE_FREE, '0, '1);
    send_request(MODE_FREE, '1, ADDR_W'(HEADER_BYTES));
    send_request(MODE_FREE, '1, ADDR_W'(HEADER_BYTES));
    send_request(MODE_ALLOC, '0, '0);
    send_request(MODE_ALLOC, '0, '0);
    // second half of the 2 KiB page, never carved yet
    send_request(MODE_FREE, '0, ADDR_W'(PAGE_BYTES + MAX_CLASS_BYTES + HEADER_BYTES));
    send_request(MODE_ALLOC, REQ_W'(MAX_CLASS_BYTES - HEADER_BYTES), '0);
    send_request(MODE_ALLOC, REQ_W'(MAX_CLASS_BYTES - HEADER_BYTES), '0);
  endtask

  task automatic test_mixed_traffic();
    wait_until_drained();
    write_pool_limit(LIMIT_W'(POOL_PAGES));
    for (int i = 0; i < 700; i++) begin
      if (i == 200) hold_off_request = 1'b1;
      if (i == 450) wait_until_drained();
      send_random(50, 40, 1'b0);
    end
  endtask

  task automatic test_lowered_limit();
    wait_until_drained();
    write_pool_limit(LIMIT_W'(pages_taken > 1 ? pages_taken / 2 : 1));
    for (int i = 0; i < 300; i++) send_random(55, 40, 1'b0);
  endtask

  task automatic test_pool_exhaustion();
    wait_until_drained();
    write_pool_limit(LIMIT_W'(POOL_PAGES));
    for (int i = 0; i < 450; i++) send_random(85, 10, 1'b1);
  endtask

  task automatic test_churn_full_rate();
    wait_until_drained();
    write_pool_limit('1);
    sender_idling = 1'b0;
    sink_idling   = 1'b0;
    for (int i = 0; i < 500; i++) send_random(45, 50, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stalls, plus one long hold when asked
  initial begin
    int unsigned burst, hold;
    burst = 0;
    hold  = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (burst != 0) begin
        out_if.ready <= 1'b0;
        burst--;
      end else if (sink_idling && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        burst = $urandom_range(0, 5);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d addr %0d",
               out_if.status, out_if.result_addr);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", 32'(want.status), 32'(out_if.status));
        check_field("result_addr", 32'(want.result_addr), 32'(out_if.result_addr));
        check_field("class_bytes", 32'(want.class_bytes), 32'(out_if.class_bytes));
        check_field("page_count", 32'(want.page_count), 32'(out_if.page_count));
        status_count[want.status]++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_outcomes.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.mode             = 1'b0;
    in_if.req_bytes        = '0;
    in_if.user_addr        = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.pool_page_limit = '0;
    mismatches       = 0;
    hold_off_request = 1'b0;
    sender_idling    = 1'b1;
    sink_idling      = 1'b1;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      free_top[k]    = '0;
      carve_at[k]    = 0;
      carve_count[k] = 0;
    end
    for (int s = 0; s < 4; s++) status_count[s] = 0;
    pages_taken = 0;
    page_limit  = LIMIT_W'(POOL_PAGES);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_limit_extremes();
    test_request_extremes();
    test_free_cases();
    test_mixed_traffic();
    test_lowered_limit();
    test_pool_exhaustion();
    test_churn_full_rate();

    wait_until_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d ok, %0d large, %0d out-of-memory and %0d rejected-free results",
             status_count[STS_OK], status_count[STS_LARGE], status_count[STS_OOM],
             status_count[STS_BADDR]);
    $display("Pool limits 0, 1, lowered, 64 and 127; %0d of %0d pages taken",
             pages_taken, POOL_PAGES);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
